// ----- hw/rtl/tpns_pkg.sv -----
// Shared types, constants and helpers for the timed PWM note scheduler.
// Used by tpns_slots, tpns_drain and timed_pwm_note_scheduler; no dependencies.
package tpns_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int PIN_W       = 6;
  localparam int LEVEL_W     = 8;
  localparam int DUR_W       = 16;
  localparam int MODE_W      = 2;
  localparam int MASK_W      = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [MASK_W-1:0] MASK_RESET = 64'd2;

  // Input item kinds
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] VEL_FULL  = 8'd127;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PIN_W-1:0]   pin;
    logic [LEVEL_W-1:0] value;
    logic [DUR_W-1:0]   duration;
  } tpns_item_t;

  // Batch of writes handed from the slot table to the output drain
  typedef struct packed {
    logic                              fire;
    logic [SLOT_COUNT-1:0]             mask;
    logic [SLOT_COUNT-1:0][PIN_W-1:0]  pins;
    logic [LEVEL_W-1:0]                level;
  } tpns_load_t;

  // velocity*255/127 saturated: equals 2*v below 127, full scale from 127 up
  function automatic logic [LEVEL_W-1:0] note_level(input logic [LEVEL_W-1:0] v);
    logic [LEVEL_W-1:0] res;
    if (v >= VEL_FULL) begin
      res = LEVEL_MAX;
    end else begin
      res = {v[LEVEL_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/tpns_slots.sv -----
// Note-off slot table: processes one registered item per cycle on fire and builds the write batch.
// Depends on tpns_pkg.
module tpns_slots
  import tpns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  tpns_item_t        item,
  input  logic [MASK_W-1:0] pin_mask,
  output tpns_load_t        load
);

  logic [SLOT_COUNT-1:0]            slot_active_r, slot_active_nxt;
  logic [SLOT_COUNT-1:0][PIN_W-1:0] slot_pin_r, slot_pin_nxt;
  logic [SLOT_COUNT-1:0][DUR_W-1:0] slot_rem_r, slot_rem_nxt;

  always_comb begin
    logic [CNT_W-1:0]      cnt;
    logic [SLOT_COUNT-1:0] keep;
    logic [SLOT_COUNT-1:0] free;
    logic [SLOT_COUNT-1:0] claim;
    slot_active_nxt = slot_active_r;
    slot_pin_nxt    = slot_pin_r;
    slot_rem_nxt    = slot_rem_r;
    load.fire       = fire;
    load.mask       = '0;
    load.pins       = slot_pin_r;
    load.level      = '0;
    cnt             = '0;
    keep            = '0;
    free            = '0;
    claim           = '0;
    case (item.mode)
      MODE_SET: begin
        load.pins[0] = item.pin;
        load.level   = item.value;
        load.mask[0] = pin_mask[item.pin];
      end
      MODE_NOTE: begin
        load.pins[0] = item.pin;
        load.level   = note_level(item.value);
        load.mask[0] = pin_mask[item.pin];
        // drop slots already holding this pin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          keep[i] = slot_active_r[i] && (slot_pin_r[i] != item.pin);
        end
        // claim the lowest free slot
        free  = ~keep;
        claim = free & (~free + SLOT_COUNT'(1));
        if ((item.value != '0) && (item.duration != '0)) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (claim[i]) begin
              slot_pin_nxt[i] = item.pin;
              slot_rem_nxt[i] = item.duration;
            end
          end
          slot_active_nxt = keep | claim;
        end else begin
          slot_active_nxt = keep;
        end
      end
      MODE_TICK: begin
        // advance countdowns, expire in slot order
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_active_r[i]) begin
            if (slot_rem_r[i] > DUR_W'(1)) begin
              slot_rem_nxt[i] = slot_rem_r[i] - DUR_W'(1);
            end else if (pin_mask[slot_pin_r[i]]) begin
              if (cnt >= CNT_W'(MAX_RESULTS)) begin
                slot_rem_nxt[i] = DUR_W'(1);
              end else begin
                load.mask[i]       = 1'b1;
                cnt                = cnt + CNT_W'(1);
                slot_active_nxt[i] = 1'b0;
              end
            end else begin
              slot_active_nxt[i] = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_active_r <= '0;
    end else if (fire) begin
      slot_active_r <= slot_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot_pin_r <= slot_pin_nxt;
      slot_rem_r <= slot_rem_nxt;
    end
  end

  // a tick never activates a slot
  a_tick_no_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (item.mode == MODE_TICK)) |=> ((slot_active_r & ~$past(slot_active_r)) == '0))
    else $error("tick activated a slot");

  // a batch never exceeds the result limit
  a_batch_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> ($countones(load.mask) <= MAX_RESULTS))
    else $error("write batch too large");

endmodule

// ----- hw/rtl/tpns_drain.sv -----
// Output drain: holds a batch of pending writes and issues one word per cycle in slot order.
// Depends on tpns_pkg.
module tpns_drain
  import tpns_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  tpns_load_t         load,
  output logic               can_load,
  output logic               out_valid,
  output logic [PIN_W-1:0]   out_pin,
  output logic [LEVEL_W-1:0] out_level,
  output logic               out_last
);

  logic [SLOT_COUNT-1:0]            pend_r, pend_nxt;
  logic [SLOT_COUNT-1:0][PIN_W-1:0] pins_r;
  logic [LEVEL_W-1:0]               level_r;
  logic                             out_valid_r, out_last_r;
  logic [PIN_W-1:0]                 out_pin_r, sel_pin;
  logic [LEVEL_W-1:0]               out_level_r;
  logic [SLOT_COUNT-1:0]            lowest, rest;

  // pick the lowest pending entry
  assign lowest   = pend_r & (~pend_r + SLOT_COUNT'(1));
  assign rest     = pend_r & ~lowest;
  assign can_load = (rest == '0);

  always_comb begin
    sel_pin = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (lowest[i]) begin
        sel_pin = sel_pin | pins_r[i];
      end
    end
  end

  // replace the queue on a new batch, otherwise pop one
  always_comb begin
    if (load.fire) begin
      pend_nxt = load.mask;
    end else begin
      pend_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= (pend_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load.fire) begin
      pins_r  <= load.pins;
      level_r <= load.level;
    end
    out_pin_r   <= sel_pin;
    out_level_r <= level_r;
    out_last_r  <= (rest == '0);
  end

  assign out_valid = out_valid_r;
  assign out_pin   = out_pin_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

  // a batch is only taken once the previous one is on its final word
  a_load_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load.fire |-> ($countones(pend_r) <= 1))
    else $error("batch loaded over pending writes");

  // a write that is not the last is followed directly by another
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=> out_valid_r)
    else $error("gap inside a write burst");

endmodule

// ----- hw/rtl/timed_pwm_note_scheduler.sv -----
// Path: an accepted item passes the input register, drain queue and output registers
// to its first PWM write, behind the rest of any earlier burst of two or more words.
// Throughput: one item per cycle while each causes at most one write; a tick expiring
// n enabled slots issues n words back to back and can hold busy until the last word.
// Reset: all slots free, pin mask = pin 1 only; the receiver cannot stall writes.
// Depends on tpns_pkg, tpns_slots and tpns_drain.
module timed_pwm_note_scheduler
  import tpns_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [PIN_W-1:0]   in_pin,
  input  logic [LEVEL_W-1:0] in_value,
  input  logic [DUR_W-1:0]   in_duration,
  output logic               out_valid,
  output logic [PIN_W-1:0]   out_pin,
  output logic [LEVEL_W-1:0] out_level,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [MASK_W-1:0]  cfg_data
);

  logic [MASK_W-1:0] pin_mask_r;
  logic              item_v_r, item_v_nxt;
  tpns_item_t        item_r;
  logic              can_load, fire, accept;
  tpns_load_t        load;

  assign cfg_ready = 1'b1;

  // hold the mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_mask_r <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pin_mask_r <= cfg_data;
    end
  end

  // input register: advance when the drain can take the batch
  assign busy   = item_v_r && !can_load;
  assign fire   = item_v_r && can_load;
  assign accept = start && !busy;

  always_comb begin
    if (accept) begin
      item_v_nxt = 1'b1;
    end else if (fire) begin
      item_v_nxt = 1'b0;
    end else begin
      item_v_nxt = item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.mode     <= in_mode;
      item_r.pin      <= in_pin;
      item_r.value    <= in_value;
      item_r.duration <= in_duration;
    end
  end

  tpns_slots u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item_r),
    .pin_mask (pin_mask_r),
    .load     (load)
  );

  tpns_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_pin   (out_pin),
    .out_level (out_level),
    .out_last  (out_last)
  );

  // an accepted item is processed in the following cycle unless a burst is draining
  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && can_load && !start) |=> !item_v_r)
    else $error("processed item not retired");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for timed_pwm_note_scheduler: directed and random commands,
// with PWM writes predicted by a local scheduler model and checked in order.
// Depends on tpns_pkg and the scheduler RTL.
module tb;
  import tpns_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [MASK_W-1:0] MASK_ALL    = {MASK_W{1'b1}};
  localparam int                DRAIN_LIMIT = 2000;
  localparam int                SETTLE_CYC  = 8;

  typedef struct {
    logic [PIN_W-1:0]   pin;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } pwm_write_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [MODE_W-1:0]  in_mode;
  logic [PIN_W-1:0]   in_pin;
  logic [LEVEL_W-1:0] in_value;
  logic [DUR_W-1:0]   in_duration;
  logic               out_valid;
  logic [PIN_W-1:0]   out_pin;
  logic [LEVEL_W-1:0] out_level;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [MASK_W-1:0]  cfg_data;

  // scheduler model state
  logic [MASK_W-1:0]  pin_mask_model;
  bit                 slot_busy [SLOT_COUNT];
  logic [PIN_W-1:0]   slot_owner [SLOT_COUNT];
  logic [DUR_W-1:0]   slot_left [SLOT_COUNT];

  pwm_write_t         pending_writes[$];
  int                 mismatch_count;
  int                 sender_idle_pct;
  logic [PIN_W-1:0]   pin_pool [8] = '{6'd0, 6'd1, 6'd5, 6'd17, 6'd32, 6'd46, 6'd62, 6'd63};

  timed_pwm_note_scheduler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_pin      (in_pin),
    .in_value    (in_value),
    .in_duration (in_duration),
    .out_valid   (out_valid),
    .out_pin     (out_pin),
    .out_level   (out_level),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Work out the PWM writes one accepted command causes and queue them
  function automatic void predict_writes(input logic [MODE_W-1:0] mode,
                                         input logic [PIN_W-1:0] pin,
                                         input logic [LEVEL_W-1:0] value,
                                         input logic [DUR_W-1:0] duration);
    pwm_write_t batch[$];
    int         lvl;
    case (mode)
      MODE_SET: begin
        if (pin_mask_model[pin]) batch.push_back('{pin: pin, level: value, last: 1'b0});
      end
      MODE_NOTE: begin
        lvl = (int'(value) * 255) / 127;
        if (lvl > 255) lvl = 255;
        if (pin_mask_model[pin]) begin
          batch.push_back('{pin: pin, level: lvl[LEVEL_W-1:0], last: 1'b0});
        end
        // drop any note-off already pending for this pin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_busy[i] && slot_owner[i] == pin) slot_busy[i] = 1'b0;
        end
        // claim the lowest free slot
        if (value != '0 && duration != '0) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_busy[i]) begin
              slot_busy[i]  = 1'b1;
              slot_owner[i] = pin;
              slot_left[i]  = duration;
              break;
            end
          end
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!slot_busy[i]) continue;
          if (slot_left[i] > DUR_W'(1)) begin
            slot_left[i] = slot_left[i] - DUR_W'(1);
            continue;
          end
          if (pin_mask_model[slot_owner[i]]) begin
            if (batch.size() >= MAX_RESULTS) begin
              slot_left[i] = DUR_W'(1);
              continue;
            end
            batch.push_back('{pin: slot_owner[i], level: '0, last: 1'b0});
          end
          slot_busy[i] = 1'b0;
          slot_left[i] = '0;
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) pending_writes.push_back(batch[k]);
  endfunction

  // Drive one command word and hold it until the block takes it
  task automatic send_command(input logic [MODE_W-1:0] mode, input logic [PIN_W-1:0] pin,
                              input logic [LEVEL_W-1:0] value,
                              input logic [DUR_W-1:0] duration);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start       = 1'b1;
    in_mode     = mode;
    in_pin      = pin;
    in_value    = value;
    in_duration = duration;
    do @(posedge clk); while (busy);
    predict_writes(mode, pin, value, duration);
  endtask

  // Stop sending and let every expected write come out
  task automatic drain_writes();
    @(negedge clk);
    start = 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_writes.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apply_pin_mask(input logic [MASK_W-1:0] mask);
    drain_writes();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = mask;
    do @(posedge clk); while (!cfg_ready);
    pin_mask_model = mask;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Compare each write with the oldest expectation
  always @(posedge clk) begin
    pwm_write_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected write pin=%0d level=%0d last=%0b",
                                out_pin, out_level, out_last));
      end else begin
        exp_w = pending_writes.pop_front();
        if (out_pin !== exp_w.pin || out_level !== exp_w.level || out_last !== exp_w.last) begin
          note_mismatch($sformatf({"write exp pin=%0d level=%0d last=%0b",
                                   " got pin=%0d level=%0d last=%0b"},
                                  exp_w.pin, exp_w.level, exp_w.last,
                                  out_pin, out_level, out_last));
        end
      end
    end
  end

  // Reset mask enables pin 1 only
  task automatic test_reset_mask();
    send_command(MODE_SET, 6'd1, 8'h5A, 16'd0);
    send_command(MODE_SET, 6'd0, 8'd255, 16'd0);
    send_command(MODE_NOTE, 6'd1, 8'd127, 16'd0);
  endtask

  // Level extremes, velocity scaling and saturation, ignored mode
  task automatic test_levels_and_velocities();
    apply_pin_mask(MASK_ALL);
    send_command(MODE_SET, 6'd0, 8'd0, 16'd0);
    send_command(MODE_SET, 6'd63, 8'd255, 16'hFFFF);
    send_command(MODE_NOTE, 6'd2, 8'd0, 16'd5);
    send_command(MODE_NOTE, 6'd3, 8'd1, 16'd0);
    send_command(MODE_NOTE, 6'd4, 8'd126, 16'd0);
    send_command(MODE_NOTE, 6'd5, 8'd128, 16'd0);
    send_command(MODE_NOTE, 6'd6, 8'd255, 16'hFFFF);
    send_command(MODE_UNUSED, 6'd63, 8'd255, 16'hFFFF);
    send_command(MODE_TICK, 6'd0, 8'd0, 16'd0);
    // zero velocity retrigger clears the long note
    send_command(MODE_NOTE, 6'd6, 8'd0, 16'd0);
  endtask

  // Fill the table past capacity, expire all slots on one tick, retrigger
  task automatic test_slot_table_full();
    for (int p = 10; p <= 18; p++) send_command(MODE_NOTE, p[PIN_W-1:0], 8'd100, 16'd1);
    send_command(MODE_TICK, 6'd0, 8'd0, 16'd0);
    send_command(MODE_NOTE, 6'd10, 8'd64, 16'd3);
    send_command(MODE_NOTE, 6'd11, 8'd64, 16'd2);
    send_command(MODE_NOTE, 6'd10, 8'd32, 16'd3);
    repeat (3) send_command(MODE_TICK, 6'd0, 8'd0, 16'd0);
  endtask

  // Slots whose pin is disabled at expiry free up silently
  task automatic test_disabled_expiry();
    send_command(MODE_NOTE, 6'd20, 8'd90, 16'd1);
    send_command(MODE_NOTE, 6'd21, 8'd90, 16'd1);
    apply_pin_mask(MASK_W'(1) << 21);
    send_command(MODE_TICK, 6'd0, 8'd0, 16'd0);
    apply_pin_mask('0);
    send_command(MODE_SET, 6'd1, 8'd77, 16'd0);
    send_command(MODE_NOTE, 6'd22, 8'd50, 16'd1);
    send_command(MODE_TICK, 6'd0, 8'd0, 16'd0);
  endtask

  // Mixed traffic: mostly pooled pins so retriggers and expiries happen often
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input logic [MASK_W-1:0] mask);
    int                 sent;
    int                 r;
    logic [PIN_W-1:0]   pin;
    logic [LEVEL_W-1:0] value;
    logic [DUR_W-1:0]   duration;
    apply_pin_mask(mask);
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < count) begin
      r     = $urandom_range(99);
      pin   = ($urandom_range(3) == 0) ? PIN_W'($urandom_range(63))
                                       : pin_pool[$urandom_range(7)];
      value = LEVEL_W'($urandom_range(255));
      duration = DUR_W'($urandom_range(65535));
      if (r < 40) begin
        send_command(MODE_TICK, pin, value, duration);
      end else if (r < 75) begin
        if ($urandom_range(9) == 0) value = '0;
        r = $urandom_range(9);
        if (r == 0) begin
          duration = '0;
        end else if (r == 1) begin
          // long notes only on pooled pins so retriggers free them
          pin = pin_pool[$urandom_range(7)];
        end else begin
          duration = DUR_W'($urandom_range(12, 1));
        end
        send_command(MODE_NOTE, pin, value, duration);
      end else if (r < 95) begin
        send_command(MODE_SET, pin, value, duration);
      end else begin
        send_command(MODE_UNUSED, pin, value, duration);
        sent--;
      end
      sent++;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_SET;
    in_pin          = '0;
    in_value        = '0;
    in_duration     = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    mismatch_count  = 0;
    sender_idle_pct = 19;
    pin_mask_model  = MASK_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_busy[i]  = 1'b0;
      slot_owner[i] = '0;
      slot_left[i]  = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_mask();
    test_levels_and_velocities();
    test_slot_table_full();
    test_disabled_expiry();
    test_random_traffic(130, 19, {$urandom, $urandom});
    test_random_traffic(140, 76, MASK_ALL);
    test_random_traffic(130, 0, {$urandom, $urandom} | MASK_RESET);

    drain_writes();
    if (pending_writes.size() != 0) begin
      note_mismatch($sformatf("%0d expected writes never came", pending_writes.size()));
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
